FILE: rtl/ttob_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the 5x8 font table for the text renderer.
// No dependencies; imported by the front, queue, back, top level and testbench.
package ttob_pkg;

	localparam int GLYPH_WIDTH = 5;
	localparam int FONT_COUNT  = 95;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] FONT_FIRST   = 8'h20;
	localparam logic [7:0] FONT_END     = 8'h7F;
	localparam logic [7:0] NEWLINE_CODE = 8'h0A;
	localparam logic [7:0] CMD_COL_WIN  = 8'h21;
	localparam logic [7:0] CMD_PAGE_WIN = 8'h22;
	localparam logic [7:0] CMD_CONTRAST = 8'h81;
	localparam logic [7:0] BLANK_COL    = 8'h00;

	// byte positions within one print or contrast sequence
	localparam logic [3:0] STEP_WIN_LAST   = 4'd5;
	localparam logic [3:0] STEP_GLYPH      = 4'd6;
	localparam logic [3:0] STEP_GLYPH_LAST = 4'd11;
	localparam logic [3:0] STEP_CTR_LAST   = 4'd1;

	typedef enum logic [1:0] {
		OP_PRINT    = 2'd0,
		OP_CURSOR   = 2'd1,
		OP_CONTRAST = 2'd2
	} op_t;

	// one unit of work handed from the front to the back
	typedef struct packed {
		logic       win;        // emit address window
		logic [7:0] win_col;
		logic [2:0] win_page;
		logic       glyph;      // emit glyph columns plus spacer
		logic       blank;      // code outside the font
		logic [6:0] glyph_idx;
		logic       contrast;   // emit contrast command pair
		logic [7:0] level;
	} desc_t;

	// column 0 in the top byte
	localparam logic [39:0] FONT_ROM [FONT_COUNT] = '{
		40'h0000000000, 40'h00002f0000, 40'h0007000700, 40'h147f147f14, 40'h242a7f2a12,
		40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001c224100, 40'h0041221c00,
		40'h14083E0814, 40'h08083E0808, 40'h0000A06000, 40'h0808080808, 40'h0060600000,
		40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
		40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
		40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
		40'h0041221408, 40'h0201510906, 40'h324959513E, 40'h7C1211127C, 40'h7F49494936,
		40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
		40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
		40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
		40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
		40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
		40'h55AA55AA55, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0003050000,
		40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
		40'h087E090102, 40'h18A4A4A47C, 40'h7F08040478, 40'h00447D4000, 40'h4080847D00,
		40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
		40'hFC24242418, 40'h18242418FC, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
		40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h1CA0A0A07C,
		40'h4464544C44, 40'h00107C8200, 40'h0000FF0000, 40'h00827C1000, 40'h0006090906
	};

endpackage

FILE: rtl/ttob_if.sv
`timescale 1ns / 1ps
// Valid/ready channels: operation items in, display bytes out.
// Stands alone; used by the front, back and top level.
interface ttob_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] char_code;
	logic [7:0] target_line;
	logic [7:0] target_column;
	logic [7:0] contrast_level;

	modport source (output valid, opcode, char_code, target_line, target_column,
		contrast_level, input ready);
	modport sink (input valid, opcode, char_code, target_line, target_column,
		contrast_level, output ready);
endinterface

interface ttob_byte_if;
	logic       valid;
	logic       ready;
	logic       is_command;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, is_command, out_byte, last, input ready);
	modport sink (input valid, is_command, out_byte, last, output ready);
endinterface

FILE: rtl/ttob_front.sv
`timescale 1ns / 1ps
// Front end: accepts operation items, keeps page and column, builds work descriptors.
// Depends on ttob_pkg and ttob_cmd_if.
module ttob_front import ttob_pkg::*; #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	ttob_cmd_if.sink   cmd,
	input  logic       q_full,
	output logic       push,
	output desc_t      push_desc
);

	logic [2:0] page_q;
	logic [7:0] col_q;
	logic [2:0] page_d;
	logic [7:0] col_d;
	logic [8:0] col_reach;
	logic [2:0] page_inc;
	logic       wrap;
	logic       is_nl;
	logic       take;
	logic       produce;

	assign cmd.ready = !q_full;
	assign take      = cmd.valid && cmd.ready;
	assign push      = take && produce;

	assign is_nl     = (cmd.char_code == NEWLINE_CODE);
	assign col_reach = {1'b0, col_q} + 9'(GLYPH_WIDTH);
	assign wrap      = (col_reach >= 9'(COLUMNS)) || is_nl;
	assign page_inc  = (({1'b0, page_q} + 4'd1) >= 4'(PAGES)) ? 3'd0 : page_q + 3'd1;

	always_comb begin
		page_d    = page_q;
		col_d     = col_q;
		produce   = 1'b0;
		push_desc = '0;
		unique case (op_t'(cmd.opcode))
			OP_PRINT: begin
				produce            = 1'b1;
				push_desc.win      = wrap;
				push_desc.win_col  = 8'd0;
				push_desc.win_page = page_inc;
				push_desc.glyph    = !is_nl;
				push_desc.blank    = (cmd.char_code < FONT_FIRST) || (cmd.char_code >= FONT_END);
				push_desc.glyph_idx = 7'(cmd.char_code - FONT_FIRST);
				if (wrap) begin
					page_d = page_inc;
					col_d  = 8'd0;
				end
				if (!is_nl) begin
					col_d = col_d + 8'(GLYPH_WIDTH + 1);
				end
			end
			OP_CURSOR: begin
				// out-of-range targets drop the item
				if (cmd.target_line < 8'(PAGES) && cmd.target_column < 8'(COLUMNS)) begin
					produce            = 1'b1;
					push_desc.win      = 1'b1;
					push_desc.win_col  = cmd.target_column;
					push_desc.win_page = cmd.target_line[2:0];
					page_d             = cmd.target_line[2:0];
					col_d              = cmd.target_column;
				end
			end
			OP_CONTRAST: begin
				produce            = 1'b1;
				push_desc.contrast = 1'b1;
				push_desc.level    = cmd.contrast_level;
			end
			default: begin
				produce = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q <= 3'd0;
			col_q  <= 8'd0;
		end else if (take) begin
			page_q <= page_d;
			col_q  <= col_d;
		end
	end

endmodule

FILE: rtl/ttob_queue.sv
`timescale 1ns / 1ps
// Short descriptor queue between front and back.
// Depends on ttob_pkg.
module ttob_queue import ttob_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	input  logic  pop,
	output desc_t head,
	output logic  full,
	output logic  empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	desc_t            slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full  = (count_q == (PTR_W + 1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
		end
	end

endmodule

FILE: rtl/ttob_back.sv
`timescale 1ns / 1ps
// Back end: walks one descriptor byte by byte into a registered output stage.
// Depends on ttob_pkg and ttob_byte_if.
module ttob_back import ttob_pkg::*; #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  desc_t       head,
	input  logic        empty,
	output logic        pop,
	ttob_byte_if.source stream
);

	logic [3:0]  k_q;
	logic [3:0]  step;
	logic        valid_q;
	logic        is_cmd_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic        load;
	logic        b_cmd;
	logic [7:0]  b_val;
	logic        b_last;
	logic [39:0] font_row;
	logic [2:0]  font_col;

	// print without wrap starts at the glyph part
	assign step     = k_q + ((head.glyph && !head.win) ? STEP_GLYPH : 4'd0);
	assign font_row = head.blank ? 40'd0 : FONT_ROM[head.glyph_idx];
	assign font_col = 3'(step - STEP_GLYPH);

	always_comb begin
		b_cmd  = 1'b1;
		b_val  = BLANK_COL;
		b_last = 1'b0;
		if (head.contrast) begin
			b_val  = (k_q == 4'd0) ? CMD_CONTRAST : head.level;
			b_last = (k_q == STEP_CTR_LAST);
		end else begin
			b_last = head.glyph ? (step == STEP_GLYPH_LAST) : (step == STEP_WIN_LAST);
			unique case (step)
				4'd0: b_val = CMD_COL_WIN;
				4'd1: b_val = head.win_col;
				4'd2: b_val = 8'(COLUMNS - 1);
				4'd3: b_val = CMD_PAGE_WIN;
				4'd4: b_val = {5'd0, head.win_page};
				4'd5: b_val = 8'(PAGES - 1);
				4'd6, 4'd7, 4'd8, 4'd9, 4'd10: begin
					b_cmd = 1'b0;
					b_val = font_row[6'(8 * (4 - int'(font_col))) +: 8];
				end
				default: begin
					b_cmd = 1'b0;
					b_val = BLANK_COL;
				end
			endcase
		end
	end

	assign load = !empty && (!valid_q || stream.ready);
	assign pop  = load && b_last;

	assign stream.valid      = valid_q;
	assign stream.is_command = is_cmd_q;
	assign stream.out_byte   = byte_q;
	assign stream.last       = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			k_q     <= 4'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				k_q     <= b_last ? 4'd0 : k_q + 4'd1;
			end else if (stream.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			is_cmd_q <= b_cmd;
			byte_q   <= b_val;
			last_q   <= b_last;
		end
	end

endmodule

FILE: rtl/text_to_oled_byte_stream.sv
`timescale 1ns / 1ps
// Top level of the text renderer: front end, descriptor queue, byte sequencer.
// Depends on ttob_pkg, ttob_if, ttob_front, ttob_queue, ttob_back.
//
//  channel | dir | payload                                                    | handshake
//  cmd     | in  | opcode, char_code, target_line, target_column, contrast_level | valid/ready
//  stream  | out | is_command, out_byte, last                                   | valid/ready
//
// The back end emits one byte per cycle while the stream is ready: a character takes 6 or 12
// bytes, a cursor move 6, a contrast write 2, set by the byte sequencer's step counter.
// The front takes an item per cycle while the two-entry queue has room.
// Reset clears page and column to zero and empties queue and output stage.
// A stalled stream holds its byte; the front keeps accepting until the queue fills.
module text_to_oled_byte_stream import ttob_pkg::*; #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	ttob_cmd_if.sink    cmd,
	ttob_byte_if.source stream
);

	logic  push;
	desc_t push_desc;
	logic  pop;
	desc_t head;
	logic  full;
	logic  empty;

	ttob_front #(.COLUMNS(COLUMNS), .PAGES(PAGES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.q_full    (full),
		.push      (push),
		.push_desc (push_desc)
	);

	ttob_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	ttob_back #(.COLUMNS(COLUMNS), .PAGES(PAGES)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.stream (stream)
	);

endmodule

FILE: rtl/ttob_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the byte stream of the text renderer, bound to the top level.
// Depends on text_to_oled_byte_stream.
module ttob_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_valid,
	input logic       s_ready,
	input logic       s_cmd,
	input logic [7:0] s_byte,
	input logic       s_last
);

	logic [3:0] cnt_q;
	logic       seen_data_q;
	logic       take;

	assign take = s_valid && s_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= 4'd0;
			seen_data_q <= 1'b0;
		end else if (take) begin
			cnt_q       <= s_last ? 4'd0 : cnt_q + 4'd1;
			seen_data_q <= s_last ? 1'b0 : (seen_data_q || !s_cmd);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_valid && !s_ready |=> s_valid && $stable(s_byte) && $stable(s_cmd) && $stable(s_last))
		else $error("stalled byte changed");

	a_group_len: assert property (@(posedge clk) disable iff (!arst_n)
		s_valid |-> cnt_q < 4'd12)
		else $error("more than twelve bytes for one item");

	a_spacer_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_valid && !s_cmd && s_last |-> s_byte == 8'h00)
		else $error("glyph did not end on a blank column");

	a_no_cmd_after_data: assert property (@(posedge clk) disable iff (!arst_n)
		s_valid && seen_data_q |-> !s_cmd)
		else $error("command byte after glyph data");

endmodule

bind text_to_oled_byte_stream ttob_checker u_ttob_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_valid (stream.valid),
	.s_ready (stream.ready),
	.s_cmd   (stream.is_command),
	.s_byte  (stream.out_byte),
	.s_last  (stream.last)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for text_to_oled_byte_stream: directed rows, then random operations.
// Depends on ttob_pkg, ttob_if and the renderer RTL; checks every display byte in order.
module testbench;
	import ttob_pkg::*;

	localparam int NUM_COLS      = 128;
	localparam int NUM_PAGES     = 8;
	localparam int RANDOM_ITEMS  = 250;
	localparam int PAUSE_AT      = 120;
	localparam int DRAIN_CYCLES  = 40;
	localparam int IDLE_LIMIT    = 2000;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	// own copy of the 5x8 font, column 0 in the top byte, codes 0x20..0x7E
	localparam logic [39:0] FONT_5X8 [95] = '{
		40'h0000000000, 40'h00002f0000, 40'h0007000700, 40'h147f147f14, 40'h242a7f2a12,
		40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001c224100, 40'h0041221c00,
		40'h14083E0814, 40'h08083E0808, 40'h0000A06000, 40'h0808080808, 40'h0060600000,
		40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
		40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
		40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
		40'h0041221408, 40'h0201510906, 40'h324959513E, 40'h7C1211127C, 40'h7F49494936,
		40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
		40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
		40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
		40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
		40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
		40'h55AA55AA55, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0003050000,
		40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
		40'h087E090102, 40'h18A4A4A47C, 40'h7F08040478, 40'h00447D4000, 40'h4080847D00,
		40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
		40'hFC24242418, 40'h18242418FC, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
		40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h1CA0A0A07C,
		40'h4464544C44, 40'h00107C8200, 40'h0000FF0000, 40'h00827C1000, 40'h0006090906
	};

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] ch;
		logic [7:0] line;
		logic [7:0] column;
		logic [7:0] level;
	} op_item_t;

	typedef struct packed {
		logic       is_command;
		logic [7:0] out_byte;
		logic       last;
	} disp_byte_t;

	// typed bytes are {is_command, out_byte}, first byte at index 0
	typedef struct packed {
		op_item_t        item;
		logic            has_typed;
		logic [2:0]      n_typed;
		logic [0:5][8:0] typed;
	} stim_row_t;

	logic clk;
	logic arst_n;

	ttob_cmd_if  cmd_ch ();
	ttob_byte_if byte_ch ();

	text_to_oled_byte_stream #(
		.COLUMNS(NUM_COLS),
		.PAGES  (NUM_PAGES)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.stream(byte_ch)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// predictor state
	logic [2:0] cur_page = 3'd0;
	logic [7:0] cur_col  = 8'd0;

	disp_byte_t rendered[$];
	disp_byte_t pending_bytes[$];

	int  mismatches = 0;
	int  tx_gap     = 0;
	int  tx_sent    = 0;
	bit  calm_tx    = 1'b0;
	int  rx_stall   = 0;
	int  rx_seen    = 0;
	bit  calm_rx    = 1'b0;
	int  idle_cycles = 0;

	function automatic logic [8:0] cmd_b(input logic [7:0] b);
		return {1'b1, b};
	endfunction

	function automatic logic [8:0] dat_b(input logic [7:0] b);
		return {1'b0, b};
	endfunction

	function automatic void add_byte(input logic is_cmd, input logic [7:0] b);
		rendered.push_back({is_cmd, b, 1'b0});
	endfunction

	function automatic void add_window(input logic [7:0] col, input logic [2:0] page);
		add_byte(1'b1, CMD_COL_WIN);
		add_byte(1'b1, col);
		add_byte(1'b1, 8'(NUM_COLS - 1));
		add_byte(1'b1, CMD_PAGE_WIN);
		add_byte(1'b1, {5'd0, page});
		add_byte(1'b1, 8'(NUM_PAGES - 1));
	endfunction

	function automatic void mark_last();
		disp_byte_t tail;
		if (rendered.size() != 0) begin
			tail = rendered.pop_back();
			tail.last = 1'b1;
			rendered.push_back(tail);
		end
	endfunction

	// Work out the display bytes for one operation and advance page and column.
	function automatic void render_op(input op_item_t it);
		logic [39:0] glyph_bits;
		int          k;
		rendered.delete();
		case (it.opcode)
			OP_PRINT: begin
				if (cur_col + GLYPH_WIDTH >= NUM_COLS || it.ch == NEWLINE_CODE) begin
					cur_page = (cur_page + 1 >= NUM_PAGES) ? 3'd0 : cur_page + 3'd1;
					cur_col  = 8'd0;
					add_window(8'd0, cur_page);
				end
				if (it.ch != NEWLINE_CODE) begin
					// codes outside the font draw as a blank glyph
					glyph_bits = 40'd0;
					if (it.ch >= FONT_FIRST && it.ch <= 8'h7E)
						glyph_bits = FONT_5X8[it.ch - FONT_FIRST];
					for (k = 0; k < GLYPH_WIDTH; k++)
						add_byte(1'b0, glyph_bits[39 - 8 * k -: 8]);
					add_byte(1'b0, BLANK_COL);
					cur_col = cur_col + 8'(GLYPH_WIDTH + 1);
				end
			end
			OP_CURSOR: begin
				if (it.line < NUM_PAGES && it.column < NUM_COLS) begin
					cur_page = it.line[2:0];
					cur_col  = it.column;
					add_window(it.column, it.line[2:0]);
				end
			end
			OP_CONTRAST: begin
				add_byte(1'b1, CMD_CONTRAST);
				add_byte(1'b1, it.level);
			end
			default: ;
		endcase
		mark_last();
	endfunction

	function automatic stim_row_t stim_row(input logic [1:0] op, input logic [7:0] ch,
		input logic [7:0] line, input logic [7:0] col, input logic [7:0] level,
		input logic has_typed, input int n, input logic [0:5][8:0] seq);
		stim_row_t r;
		r.item      = '{opcode: op, ch: ch, line: line, column: col, level: level};
		r.has_typed = has_typed;
		r.n_typed   = 3'(n);
		r.typed     = seq;
		return r;
	endfunction

	// Present one item, hold it until accepted, then queue what it should produce.
	task automatic send_item(input op_item_t it, input bit more);
		disp_byte_t b;
		repeat (tx_gap) @(posedge clk);
		cmd_ch.valid          <= 1'b1;
		cmd_ch.opcode         <= it.opcode;
		cmd_ch.char_code      <= it.ch;
		cmd_ch.target_line    <= it.line;
		cmd_ch.target_column  <= it.column;
		cmd_ch.contrast_level <= it.level;
		do @(posedge clk); while (!cmd_ch.ready);
		foreach (rendered[j]) begin
			b = rendered[j];
			pending_bytes.push_back(b);
		end
		tx_sent++;
		if (tx_sent % 40 == 0)
			calm_tx = ($urandom_range(0, 3) == 0);
		tx_gap = calm_tx ? 0 : $urandom_range(0, 7);
		// keep valid high only when the next item follows at once
		if (tx_gap != 0 || !more)
			cmd_ch.valid <= 1'b0;
	endtask

	// always advance the clock before checking, so a dropped valid settles before the next item
	task automatic wait_until_drained();
		do @(posedge clk); while (pending_bytes.size() != 0);
	endtask

	initial begin : stimulus
		stim_row_t rows[$];
		op_item_t  it;
		int        k;
		int        served;
		int        sent;
		int        sel;
		int        r;

		arst_n                = 1'b0;
		cmd_ch.valid          = 1'b0;
		cmd_ch.opcode         = OP_PRINT;
		cmd_ch.char_code      = 8'd0;
		cmd_ch.target_line    = 8'd0;
		cmd_ch.target_column  = 8'd0;
		cmd_ch.contrast_level = 8'd0;

		// state after reset: page 0, column 0
		rows.push_back(stim_row(OP_PRINT, 8'h41, 8'h00, 8'h00, 8'h00, 1, 6,
			{dat_b(8'h7C), dat_b(8'h12), dat_b(8'h11), dat_b(8'h12), dat_b(8'h7C),
			dat_b(BLANK_COL)}));
		rows.push_back(stim_row(OP_CONTRAST, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1, 2,
			{cmd_b(CMD_CONTRAST), cmd_b(8'h00), 36'd0}));
		rows.push_back(stim_row(OP_CONTRAST, 8'h00, 8'h00, 8'h00, 8'hFF, 1, 2,
			{cmd_b(CMD_CONTRAST), cmd_b(8'hFF), 36'd0}));
		// out-of-range cursor and the spare opcode leave no trace
		rows.push_back(stim_row(OP_CURSOR, 8'h00, 8'h08, 8'h00, 8'h00, 1, 0, '0));
		rows.push_back(stim_row(OP_CURSOR, 8'h00, 8'h00, 8'h80, 8'h00, 1, 0, '0));
		rows.push_back(stim_row(OP_CURSOR, 8'h00, 8'hFF, 8'hFF, 8'h00, 1, 0, '0));
		rows.push_back(stim_row(OP_UNUSED, 8'h41, 8'h03, 8'h10, 8'h55, 1, 0, '0));
		rows.push_back(stim_row(OP_CURSOR, 8'h00, 8'h00, 8'h00, 8'h00, 1, 6,
			{cmd_b(CMD_COL_WIN), cmd_b(8'h00), cmd_b(8'h7F), cmd_b(CMD_PAGE_WIN),
			cmd_b(8'h00), cmd_b(8'h07)}));
		rows.push_back(stim_row(OP_PRINT, 8'h20, 8'h00, 8'h00, 8'h00, 0, 0, '0));
		rows.push_back(stim_row(OP_PRINT, 8'h7E, 8'h00, 8'h00, 8'h00, 0, 0, '0));
		rows.push_back(stim_row(OP_PRINT, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, '0));
		rows.push_back(stim_row(OP_PRINT, 8'h1F, 8'h00, 8'h00, 8'h00, 0, 0, '0));
		rows.push_back(stim_row(OP_PRINT, 8'h7F, 8'h00, 8'h00, 8'h00, 0, 0, '0));
		rows.push_back(stim_row(OP_PRINT, 8'hFF, 8'h00, 8'h00, 8'h00, 0, 0, '0));
		rows.push_back(stim_row(OP_PRINT, 8'h0B, 8'h00, 8'h00, 8'h00, 0, 0, '0));
		rows.push_back(stim_row(OP_PRINT, NEWLINE_CODE, 8'h00, 8'h00, 8'h00, 0, 0, '0));
		rows.push_back(stim_row(OP_CURSOR, 8'h00, 8'h07, 8'h7F, 8'h00, 1, 6,
			{cmd_b(CMD_COL_WIN), cmd_b(8'h7F), cmd_b(8'h7F), cmd_b(CMD_PAGE_WIN),
			cmd_b(8'h07), cmd_b(8'h07)}));
		// glyph does not fit on the last page: wrap to page 0, twelve bytes
		rows.push_back(stim_row(OP_PRINT, 8'h7A, 8'h00, 8'h00, 8'h00, 0, 0, '0));
		rows.push_back(stim_row(OP_CURSOR, 8'h00, 8'h07, 8'h7A, 8'h00, 1, 6,
			{cmd_b(CMD_COL_WIN), cmd_b(8'h7A), cmd_b(8'h7F), cmd_b(CMD_PAGE_WIN),
			cmd_b(8'h07), cmd_b(8'h07)}));
		rows.push_back(stim_row(OP_PRINT, 8'h7E, 8'h00, 8'h00, 8'h00, 0, 0, '0));
		rows.push_back(stim_row(OP_PRINT, 8'h21, 8'h00, 8'h00, 8'h00, 0, 0, '0));
		rows.push_back(stim_row(OP_CURSOR, 8'h00, 8'h03, 8'h7B, 8'h00, 1, 6,
			{cmd_b(CMD_COL_WIN), cmd_b(8'h7B), cmd_b(8'h7F), cmd_b(CMD_PAGE_WIN),
			cmd_b(8'h03), cmd_b(8'h07)}));
		rows.push_back(stim_row(OP_PRINT, 8'h51, 8'h00, 8'h00, 8'h00, 0, 0, '0));
		rows.push_back(stim_row(OP_CURSOR, 8'h00, 8'h07, 8'h00, 8'h00, 0, 0, '0));
		rows.push_back(stim_row(OP_PRINT, NEWLINE_CODE, 8'h00, 8'h00, 8'h00, 0, 0, '0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			render_op(rows[i].item);
			if (rows[i].has_typed) begin
				rendered.delete();
				for (k = 0; k < rows[i].n_typed; k++)
					rendered.push_back({rows[i].typed[k], 1'b0});
				mark_last();
			end
			send_item(rows[i].item, i != rows.size() - 1);
		end
		wait_until_drained();

		served = 0;
		sent   = 0;
		while (served < RANDOM_ITEMS) begin
			// noise in the fields an operation does not use
			it.ch     = 8'($urandom);
			it.line   = 8'($urandom);
			it.column = 8'($urandom);
			it.level  = 8'($urandom);
			sel = $urandom_range(0, 99);
			r   = $urandom_range(0, 19);
			if (sel < 60) begin
				it.opcode = OP_PRINT;
				if (r < 2)
					it.ch = NEWLINE_CODE;
				else if (r >= 4)
					it.ch = 8'($urandom_range(8'h20, 8'h7E));
			end else if (sel < 78) begin
				it.opcode = OP_CURSOR;
				if (r >= 2) begin
					it.line   = 8'($urandom_range(0, NUM_PAGES - 1));
					it.column = (r < 9) ? 8'($urandom_range(110, NUM_COLS - 1))
						: 8'($urandom_range(0, NUM_COLS - 1));
				end
			end else if (sel < 95) begin
				it.opcode = OP_CONTRAST;
			end else begin
				it.opcode = OP_UNUSED;
			end
			render_op(it);
			if (rendered.size() != 0)
				served++;
			sent++;
			send_item(it, served < RANDOM_ITEMS && sent != PAUSE_AT);
			if (sent == PAUSE_AT)
				wait_until_drained();
		end

		wait_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin : byte_sink
		disp_byte_t want;
		disp_byte_t got;

		byte_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_stall != 0) begin
				byte_ch.ready <= 1'b0;
				repeat (rx_stall) @(posedge clk);
			end
			byte_ch.ready <= 1'b1;
			do @(posedge clk); while (!byte_ch.valid);
			got = {byte_ch.is_command, byte_ch.out_byte, byte_ch.last};
			if (pending_bytes.size() == 0) begin
				$display("%0t: unexpected byte, expected none, got cmd=%0b byte=%02h last=%0b",
					$time, got.is_command, got.out_byte, got.last);
				mismatches++;
			end else begin
				want = pending_bytes.pop_front();
				if (got.is_command !== want.is_command) begin
					$display("%0t: is_command expected %0b got %0b",
						$time, want.is_command, got.is_command);
					mismatches++;
				end
				if (got.out_byte !== want.out_byte) begin
					$display("%0t: out_byte expected %02h got %02h",
						$time, want.out_byte, got.out_byte);
					mismatches++;
				end
				if (got.last !== want.last) begin
					$display("%0t: last expected %0b got %0b", $time, want.last, got.last);
					mismatches++;
				end
			end
			rx_seen++;
			if (rx_seen % 48 == 0)
				calm_rx = ($urandom_range(0, 3) == 0);
			rx_stall = calm_rx ? 0 : $urandom_range(0, 7);
		end
	end

	// abort when neither channel moves an item for too long
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (byte_ch.valid && byte_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

endmodule
